>>> rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_STRAY    = 3'd1;
   localparam logic [2:0] ERR_TRUNC    = 3'd2;
   localparam logic [2:0] ERR_BAD_CONT = 3'd3;
   localparam logic [2:0] ERR_BAD_LEAD = 3'd4;

   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [2:0]  error_code;
      logic        run_last;
      logic        at_string_end;
   } rsp_type;

endpackage

>>> rtl/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Decodes a UTF-8 byte stream into UTF-16 code units with error reporting.
// ----------------------------------------------------------------------------
//  channel  dir  payload   transfer
//  req_     in   req_type  req_valid & !req_stall
//  rsp_     out  rsp_type  rsp_valid & !rsp_stall
//
//  One byte per cycle while req_stall is low; a byte that completes a surrogate
//  pair sends its high surrogate to the result register, its low to the spill.
//  Decode is one combinational pass from the sequence state to the result
//  register. Reset clears sequence state and empties both output registers.
//  req_stall is high while the spill register holds the low surrogate or the
//  result register is full and stalled.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  u8u16_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output u8u16_pkg::rsp_type  rsp_data
);
   import u8u16_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] partial_ff, partial_in;
   logic        four_ff, four_in;
   logic        drop_ff, drop_in;

   logic        out_valid_ff;
   rsp_type     out_data_ff;
   logic        spill_valid_ff;
   rsp_type     spill_data_ff;

   logic        accept;
   logic        out_free;
   logic [1:0]  res_count;
   rsp_type     res0, res1;
   logic        err_hit;
   logic [2:0]  err_val;
   logic [7:0]  b;
   logic        e;
   logic [20:0] value;
   logic [20:0] supp;

   assign b         = req_data.byte_in;
   assign e         = req_data.string_end;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = spill_valid_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign value = {partial_ff[14:0], b[5:0]};
   assign supp  = value - SUPP_BASE;

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      four_in    = four_ff;
      drop_in    = drop_ff;
      res_count  = 2'd0;
      res0       = '0;
      res1       = '0;
      err_hit    = 1'b0;
      err_val    = ERR_NONE;
      res0.at_string_end = e;
      res1.at_string_end = e;
      if (drop_ff) begin
         if (e) begin
            drop_in = 1'b0;
         end
      end else if (pending_ff == 2'd0) begin
         if (!b[7]) begin
            res_count      = 2'd1;
            res0.code_unit = {8'd0, b};
            res0.run_last  = 1'b1;
         end else if (!b[6]) begin
            err_hit = 1'b1;
            err_val = ERR_STRAY;
         end else begin
            if (!b[5]) begin
               pending_in = 2'd1;
               partial_in = {16'd0, b[4:0]};
               four_in    = 1'b0;
            end else if (!b[4]) begin
               pending_in = 2'd2;
               partial_in = {17'd0, b[3:0]};
               four_in    = 1'b0;
            end else if (!b[3]) begin
               pending_in = 2'd3;
               partial_in = {18'd0, b[2:0]};
               four_in    = 1'b1;
            end else begin
               err_hit = 1'b1;
               err_val = ERR_BAD_LEAD;
            end
            if (e && !err_hit) begin
               err_hit = 1'b1;
               err_val = ERR_TRUNC;
            end
         end
      end else if (e && pending_ff > 2'd1) begin
         err_hit = 1'b1;
         err_val = ERR_TRUNC;
      end else if (b[7:6] != 2'b10) begin
         err_hit = 1'b1;
         err_val = ERR_BAD_CONT;
      end else begin
         pending_in = pending_ff - 2'd1;
         partial_in = value;
         if (pending_ff == 2'd1) begin
            partial_in = '0;
            four_in    = 1'b0;
            if (four_ff && value >= SUPP_BASE) begin
               res_count      = 2'd2;
               res0.code_unit = HIGH_SURR | {5'd0, supp[20:10]};
               res1.code_unit = LOW_SURR | {6'd0, supp[9:0]};
               res1.run_last  = 1'b1;
            end else begin
               res_count      = 2'd1;
               res0.code_unit = value[15:0];
               res0.run_last  = 1'b1;
            end
         end
      end
      if (err_hit) begin
         pending_in      = 2'd0;
         partial_in      = '0;
         four_in         = 1'b0;
         drop_in         = !e;
         res_count       = 2'd1;
         res0.code_unit  = '0;
         res0.error_code = err_val;
         res0.run_last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         four_ff    <= 1'b0;
         drop_ff    <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         four_ff    <= four_in;
         drop_ff    <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
      end else if (spill_valid_ff && out_free) begin
         out_valid_ff   <= 1'b1;
         spill_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff   <= res_count != 2'd0;
         spill_valid_ff <= res_count == 2'd2;
      end else if (out_free) begin
         out_valid_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (spill_valid_ff && out_free) begin
         out_data_ff <= spill_data_ff;
      end else if (accept) begin
         out_data_ff   <= res0;
         spill_data_ff <= res1;
      end
   end

   // spill only ever sits behind a full result register
   a_spill_behind_out: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> out_valid_ff)
      else $error("spill register valid with empty result register");

   // spill holds the closing low surrogate of a pair
   a_spill_low_surr: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> (spill_data_ff.run_last && spill_data_ff.code_unit[15:10] == 6'h37
                          && spill_data_ff.error_code == ERR_NONE))
      else $error("spill register does not hold a low surrogate");

   // error results carry a zero code unit and close the byte
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code != ERR_NONE) |->
         (rsp_data.code_unit == 16'd0 && rsp_data.run_last))
      else $error("error result with nonzero code unit");

   // no input taken while the low surrogate waits
   a_no_accept_spill: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> !accept)
      else $error("input accepted while spill register full");

   // a high surrogate is always followed by the spilled low surrogate
   a_pair_follow: assert property (@(posedge clock) disable iff (reset)
      (accept && res_count == 2'd2) |=> (spill_valid_ff && !out_data_ff.run_last))
      else $error("surrogate pair not staged in order");

endmodule
